>>> hw/rtl/tlps_pkg.sv
package tlps_pkg;

  localparam int POS_W  = 16;
  localparam int TIME_W = 32;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = $clog2(TIME_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_e_t;

  // Operations the controller asks of the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_DIV_STEP,
    OP_MUL,
    OP_APPLY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic steps_nz;
  } dp_sts_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position_value;
    logic [TIME_W-1:0] duration_us;
    logic [TIME_W-1:0] now_time_us;
  } req_item_t;

  typedef struct packed {
    logic             wrote_position;
    logic [POS_W-1:0] current_position;
    logic             arrived;
    logic             finished;
    logic             notify_pending;
    logic             notify_fired;
  } rsp_item_t;

endpackage

>>> hw/rtl/tlps_req_if.sv
interface tlps_req_if;
  logic                        valid;
  logic                        ready;
  logic [tlps_pkg::CMD_W-1:0]  command;
  logic [tlps_pkg::POS_W-1:0]  position_value;
  logic [tlps_pkg::TIME_W-1:0] duration_us;
  logic [tlps_pkg::TIME_W-1:0] now_time_us;

  modport source (
    output valid, command, position_value, duration_us, now_time_us,
    input  ready
  );
  modport sink (
    input  valid, command, position_value, duration_us, now_time_us,
    output ready
  );
endinterface

>>> hw/rtl/tlps_rsp_if.sv
interface tlps_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       wrote_position;
  logic [tlps_pkg::POS_W-1:0] current_position;
  logic                       arrived;
  logic                       finished;
  logic                       notify_pending;
  logic                       notify_fired;

  modport source (
    output valid, wrote_position, current_position, arrived, finished,
           notify_pending, notify_fired,
    input  ready
  );
  modport sink (
    input  valid, wrote_position, current_position, arrived, finished,
           notify_pending, notify_fired,
    output ready
  );
endinterface

>>> hw/rtl/timed_linear_position_stepper_unit.sv
// Channel | Dir | Payload
// req     | in  | command, position_value, duration_us, now_time_us
// rsp     | out | wrote_position, current_position, arrived, finished, notify_pending, notify_fired
//
// Set position, acknowledge and ticks that need no division pass accept, execute and load
// (S_IDLE, S_EXEC, S_OUT). Schedule with nonzero distance and a dividing tick also run the
// 32-step radix-2 divider (S_DIV) and the multiply (S_MUL) before the load, and a tick that
// steps also applies the move (S_APPLY). One item at a time.
// Reset (rst, synchronous) leaves position 0 and the move done.
// A stalled rsp holds the next result in S_OUT; req is taken again once it is loaded.
module timed_linear_position_stepper_unit (
  input  logic       clk,
  input  logic       rst,
  tlps_req_if.sink   req,
  tlps_rsp_if.source rsp
);
  import tlps_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  req_item_t req_item;
  rsp_item_t rsp_item;

  assign req_item.command        = req.command;
  assign req_item.position_value = req.position_value;
  assign req_item.duration_us    = req.duration_us;
  assign req_item.now_time_us    = req.now_time_us;

  tlps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tlps_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_item (req_item),
    .rsp_item (rsp_item)
  );

  assign rsp.wrote_position   = rsp_item.wrote_position;
  assign rsp.current_position = rsp_item.current_position;
  assign rsp.arrived          = rsp_item.arrived;
  assign rsp.finished         = rsp_item.finished;
  assign rsp.notify_pending   = rsp_item.notify_pending;
  assign rsp.notify_fired     = rsp_item.notify_fired;

  // Loading the datapath coincides with an accepted item
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) == (cmd.op == OP_LOAD))
    else $error("datapath load does not match accepted item");

  // Only one item in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while another is in flight");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten while stalled");

  // No result is loaded while an accepted item is still in execution
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !cmd.out_load)
    else $error("result loaded too early");

endmodule

>>> hw/rtl/tlps_ctrl.sv
module tlps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tlps_pkg::dp_cmd_t cmd,
  input  tlps_pkg::dp_sts_t sts
);
  import tlps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_MUL,
    S_APPLY,
    S_OUT
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             slot_free;

  assign req_ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;

  // Decode the datapath operation and the next state
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.op     = OP_EXEC;
        state_next = sts.div_needed ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (count == CNT_W'(TIME_W - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = sts.steps_nz ? S_APPLY : S_OUT;
      end
      S_APPLY: begin
        cmd.op     = OP_APPLY;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state, divider step count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        count <= count + 1'b1;
      end else begin
        count <= '0;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/tlps_datapath.sv
module tlps_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tlps_pkg::dp_cmd_t   cmd,
  output tlps_pkg::dp_sts_t   sts,
  input  tlps_pkg::req_item_t req_item,
  output tlps_pkg::rsp_item_t rsp_item
);
  import tlps_pkg::*;

  // Motion state
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  remaining_steps;
  logic              moving_up;
  logic              move_done;
  logic              pending_notify;
  logic [TIME_W-1:0] step_interval_us;
  logic [TIME_W-1:0] reference_time_us;

  // Current item
  cmd_e_t            it_cmd;
  logic [POS_W-1:0]  it_pos;
  logic [TIME_W-1:0] it_dur;
  logic [TIME_W-1:0] it_now;

  // Divider and multiplier
  logic [TIME_W-1:0]       div_rem;
  logic [TIME_W-1:0]       div_quot;
  logic [TIME_W-1:0]       divisor;
  logic [TIME_W:0]         shifted;
  logic [TIME_W:0]         diff;
  logic [TIME_W-1:0]       product;
  logic [POS_W+TIME_W-1:0] mul_full;

  // Result flags
  logic wrote;
  logic arrived;
  logic finished;
  logic fired;

  logic             up;
  logic [POS_W-1:0] span;
  logic             idle_tick;
  logic [POS_W-1:0] steps;
  logic [POS_W-1:0] take;
  logic [POS_W-1:0] left;

  always_comb begin
    up        = it_pos > position;
    span      = up ? (it_pos - position) : (position - it_pos);
    idle_tick = (remaining_steps == '0) && move_done;
    shifted   = {div_rem, div_quot[TIME_W-1]};
    diff      = shifted - {1'b0, divisor};
    steps     = div_quot[POS_W-1:0];
    take      = (steps > remaining_steps) ? remaining_steps : steps;
    left      = remaining_steps - take;
    mul_full  = steps * step_interval_us;

    sts.div_needed = ((it_cmd == CMD_SCHED) && (span != '0)) ||
                     ((it_cmd == CMD_TICK) && !idle_tick && (step_interval_us != '0));
    sts.steps_nz   = (it_cmd == CMD_TICK) && (steps != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position          <= '0;
      remaining_steps   <= '0;
      moving_up         <= 1'b0;
      move_done         <= 1'b1;
      pending_notify    <= 1'b0;
      step_interval_us  <= '0;
      reference_time_us <= '0;
    end else begin
      unique case (cmd.op)
        OP_NONE: begin
        end
        OP_LOAD: begin
          it_cmd <= cmd_e_t'(req_item.command);
          it_pos <= req_item.position_value;
          it_dur <= req_item.duration_us;
          it_now <= req_item.now_time_us;
        end
        // Run the item's immediate part and seed the divider
        OP_EXEC: begin
          wrote    <= 1'b0;
          arrived  <= 1'b0;
          finished <= 1'b0;
          fired    <= 1'b0;
          div_rem  <= '0;
          if (it_cmd == CMD_SCHED) begin
            div_quot <= it_dur;
            divisor  <= {{(TIME_W-POS_W){1'b0}}, span};
          end else begin
            div_quot <= it_now - reference_time_us;
            divisor  <= step_interval_us;
          end
          unique case (it_cmd)
            CMD_SET: begin
              position          <= it_pos;
              remaining_steps   <= '0;
              step_interval_us  <= '0;
              move_done         <= 1'b1;
              pending_notify    <= 1'b0;
              reference_time_us <= it_now;
            end
            CMD_SCHED: begin
              moving_up         <= up;
              remaining_steps   <= span;
              reference_time_us <= it_now;
              if (span == '0) begin
                move_done        <= 1'b1;
                step_interval_us <= '0;
                pending_notify   <= 1'b1;
                finished         <= 1'b1;
              end else begin
                move_done      <= 1'b0;
                pending_notify <= 1'b0;
              end
            end
            CMD_TICK: begin
              if (idle_tick) begin
                finished <= 1'b1;
              end else if (step_interval_us == '0) begin
                reference_time_us <= it_now;
                finished          <= move_done;
              end
            end
            CMD_ACK: begin
              if (pending_notify) begin
                pending_notify <= 1'b0;
                fired          <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        // One restoring division step
        OP_DIV_STEP: begin
          if (!diff[TIME_W]) begin
            div_rem  <= diff[TIME_W-1:0];
            div_quot <= {div_quot[TIME_W-2:0], 1'b1};
          end else begin
            div_rem  <= shifted[TIME_W-1:0];
            div_quot <= {div_quot[TIME_W-2:0], 1'b0};
          end
        end
        // Store the interval, or scale the step count back to time
        OP_MUL: begin
          if (it_cmd == CMD_SCHED) begin
            step_interval_us <= div_quot;
          end
          product <= mul_full[TIME_W-1:0];
        end
        // Advance the reference time and the position
        OP_APPLY: begin
          reference_time_us <= reference_time_us + product;
          position          <= moving_up ? (position + take) : (position - take);
          remaining_steps   <= left;
          wrote             <= 1'b1;
          if (left == '0) begin
            move_done      <= 1'b1;
            arrived        <= 1'b1;
            pending_notify <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_item.wrote_position   <= wrote;
      rsp_item.current_position <= position;
      rsp_item.arrived          <= arrived;
      rsp_item.finished         <= finished;
      rsp_item.notify_pending   <= pending_notify;
      rsp_item.notify_fired     <= fired;
    end
  end

endmodule

>>> verif/timed_linear_position_stepper_unit_test.sv
`timescale 1ns / 100ps

module timed_linear_position_stepper_unit_test;
  import tlps_pkg::*;

  localparam int TOTAL_ITEMS = 1650;
  localparam int HOLD_CYCLES = 500;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;

  // Shadow copy of the stepper: tracks its state and the results it owes
  class stepper_shadow;
    bit [POS_W-1:0]  position;
    bit [POS_W-1:0]  remaining;
    bit              moving_up;
    bit              move_done;
    bit              notify_waiting;
    bit [TIME_W-1:0] step_interval;
    bit [TIME_W-1:0] reference_time;
    rsp_item_t       results_due[$];
    int              errors;
    int              results_checked;
    int              arrivals;
    int              acks_fired;

    function void clear_state();
      position       = '0;
      remaining      = '0;
      moving_up      = 1'b0;
      move_done      = 1'b1;
      notify_waiting = 1'b0;
      step_interval  = '0;
      reference_time = '0;
      results_due.delete();
    endfunction

    // Apply one accepted item and queue the result it must produce
    function void advance_stepper(req_item_t it);
      rsp_item_t       r;
      bit [TIME_W-1:0] elapsed;
      bit [TIME_W-1:0] quotient;
      bit [TIME_W-1:0] steps_wide;
      bit [POS_W-1:0]  steps;
      bit [POS_W-1:0]  take;
      r = '0;
      case (cmd_e_t'(it.command))
        CMD_SET: begin
          position       = it.position_value;
          remaining      = '0;
          step_interval  = '0;
          move_done      = 1'b1;
          notify_waiting = 1'b0;
          reference_time = it.now_time_us;
        end
        CMD_SCHED: begin
          move_done      = 1'b0;
          moving_up      = it.position_value > position;
          remaining      = moving_up ? it.position_value - position
                                     : position - it.position_value;
          reference_time = it.now_time_us;
          if (remaining == 0) begin
            move_done      = 1'b1;
            step_interval  = '0;
            notify_waiting = 1'b1;
            r.finished     = 1'b1;
          end else begin
            step_interval  = it.duration_us / {16'b0, remaining};
            notify_waiting = 1'b0;
          end
        end
        CMD_TICK: begin
          if (remaining == 0 && move_done) begin
            r.finished = 1'b1;
          end else if (step_interval == 0) begin
            reference_time = it.now_time_us;
            r.finished     = move_done;
          end else begin
            elapsed  = it.now_time_us - reference_time;
            quotient = elapsed / step_interval;
            steps    = quotient[POS_W-1:0];
            if (steps != 0) begin
              steps_wide     = {16'b0, steps};
              reference_time = reference_time + steps_wide * step_interval;
              take           = (steps > remaining) ? remaining : steps;
              position       = moving_up ? position + take : position - take;
              remaining      = remaining - take;
              r.wrote_position = 1'b1;
              if (remaining == 0) begin
                move_done      = 1'b1;
                notify_waiting = 1'b1;
                r.arrived      = 1'b1;
              end
            end
          end
        end
        CMD_ACK: begin
          if (notify_waiting) begin
            notify_waiting = 1'b0;
            r.notify_fired = 1'b1;
          end
        end
      endcase
      r.current_position = position;
      r.notify_pending   = notify_waiting;
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // Match one delivered result against the oldest one owed
    function void compare_result(rsp_item_t got);
      rsp_item_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none actual %p", $time, got);
        return;
      end
      want = results_due.pop_front();
      results_checked++;
      if (want.arrived) arrivals++;
      if (want.notify_fired) acks_fired++;
      compare_field("wrote_position", want.wrote_position, got.wrote_position);
      compare_field("current_position", want.current_position, got.current_position);
      compare_field("arrived", want.arrived, got.arrived);
      compare_field("finished", want.finished, got.finished);
      compare_field("notify_pending", want.notify_pending, got.notify_pending);
      compare_field("notify_fired", want.notify_fired, got.notify_fired);
    endfunction
  endclass

  logic clk;
  logic rst;

  tlps_req_if req_ch ();
  tlps_rsp_if rsp_ch ();

  timed_linear_position_stepper_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  stepper_shadow   shadow = new();
  bit              idle_on = 1'b1;
  bit              hold_req = 1'b0;
  int              items_sent = 0;
  int              quiet_cycles = 0;
  bit [TIME_W-1:0] clock_us;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receive side: random stalls, plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        rsp_ch.ready = !(idle_on && $urandom_range(99) < 17);
      end
    end
  end

  // Check each delivered result
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      shadow.compare_result('{rsp_ch.wrote_position, rsp_ch.current_position,
                              rsp_ch.arrived, rsp_ch.finished,
                              rsp_ch.notify_pending, rsp_ch.notify_fired});
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_item_t pack_item(cmd_e_t c, logic [POS_W-1:0] pv,
                                          logic [TIME_W-1:0] dur,
                                          logic [TIME_W-1:0] now);
    req_item_t it;
    it.command        = c;
    it.position_value = pv;
    it.duration_us    = dur;
    it.now_time_us    = now;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input req_item_t it);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 17) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid          = 1'b1;
    req_ch.command        = it.command;
    req_ch.position_value = it.position_value;
    req_ch.duration_us    = it.duration_us;
    req_ch.now_time_us    = it.now_time_us;
    do @(posedge clk); while (!req_ch.ready);
    shadow.advance_stepper(it);
    items_sent++;
  endtask

  task automatic send(cmd_e_t c, logic [POS_W-1:0] pv, logic [TIME_W-1:0] dur,
                      logic [TIME_W-1:0] now);
    send_item(pack_item(c, pv, dur, now));
  endtask

  // One move: optional load, schedule, a run of ticks, usually an acknowledge
  task automatic run_move();
    bit [POS_W-1:0]  base;
    bit [POS_W-1:0]  target;
    bit [TIME_W-1:0] dur;
    bit [TIME_W-1:0] est;
    bit [TIME_W-1:0] gap;
    int              span;
    int              pick;
    int              n_ticks;
    base = shadow.position;
    if ($urandom_range(1)) begin
      base = 16'($urandom());
      send(CMD_SET, base, $urandom(), clock_us);
    end
    pick = $urandom_range(99);
    if (pick < 60)      span = $urandom_range(1, 16);
    else if (pick < 75) span = 0;
    else if (pick < 90) span = $urandom_range(17, 400);
    else                span = $urandom_range(0, 65535);
    target = $urandom_range(1) ? base + span[POS_W-1:0] : base - span[POS_W-1:0];
    pick = $urandom_range(99);
    if (span == 0 || pick >= 85) begin
      dur = $urandom();
    end else if (pick < 50) begin
      est = $urandom_range(1, 40);
      dur = est * span + $urandom_range(0, est - 1);
    end else if (pick < 65) begin
      dur = $urandom_range(0, span);
    end else begin
      est = $urandom_range(41, 5000);
      dur = est * span + $urandom_range(0, est - 1);
    end
    send(CMD_SCHED, target, dur, clock_us);
    est = (span == 0) ? 32'd10 : dur / span;
    n_ticks = $urandom_range(1, 10);
    repeat (n_ticks) begin
      pick = $urandom_range(99);
      if (pick >= 90)
        gap = $urandom();
      else if (pick >= 75)
        gap = est * span + est;
      else if (est == 0)
        gap = $urandom_range(0, 50);
      else if (est > 32'h0FFF_FFFF)
        gap = $urandom();
      else
        gap = $urandom_range(0, est * 3 + 2);
      clock_us = clock_us + gap;
      send(CMD_TICK, 16'($urandom()), $urandom(), clock_us);
      if ($urandom_range(19) == 0) send(CMD_ACK, 16'($urandom()), $urandom(), $urandom());
    end
    if ($urandom_range(3) != 0) send(CMD_ACK, 16'($urandom()), $urandom(), $urandom());
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    int tail;
    hold_done             = 1'b0;
    drain_done            = 1'b0;
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.command        = CMD_SET;
    req_ch.position_value = '0;
    req_ch.duration_us    = '0;
    req_ch.now_time_us    = '0;
    shadow.clear_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Idle tick, empty acknowledge, zero distance
    send(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send(CMD_ACK, 16'h0, 32'h0, 32'h0);
    send(CMD_SET, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
    send(CMD_SCHED, 16'hFFFF, 32'd1000, 32'h10);
    send(CMD_TICK, 16'h0, 32'h0, 32'h20);
    send(CMD_ACK, 16'h0, 32'h0, 32'h0);
    // Short move: no step, partial step, overshoot, then idle tick
    send(CMD_SET, 16'd100, 32'h0, 32'd1000);
    send(CMD_SCHED, 16'd110, 32'd100, 32'd1000);
    send(CMD_TICK, 16'h0, 32'h0, 32'd1005);
    send(CMD_TICK, 16'h0, 32'h0, 32'd1030);
    send(CMD_TICK, 16'h0, 32'h0, 32'd2000);
    send(CMD_TICK, 16'h0, 32'h0, 32'd2100);
    send(CMD_ACK, 16'h0, 32'h0, 32'h0);
    // Duration shorter than distance: interval of zero, position frozen
    send(CMD_SET, 16'h0, 32'h0, 32'h0);
    send(CMD_SCHED, 16'hFFFF, 32'd5, 32'h0);
    send(CMD_TICK, 16'h0, 32'h0, 32'd100);
    send(CMD_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
    // Quotient wider than 16 bits truncates to zero, then to a small count
    send(CMD_SET, 16'h0, 32'h0, 32'h0);
    send(CMD_SCHED, 16'd1, 32'd1, 32'h0);
    send(CMD_TICK, 16'h0, 32'h0, 32'h0001_0000);
    send(CMD_TICK, 16'h0, 32'h0, 32'h0001_0005);
    // Downward move across the time wrap, then a full-range move
    send(CMD_SET, 16'd50, 32'h0, 32'hFFFF_FFF0);
    send(CMD_SCHED, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send(CMD_TICK, 16'h0, 32'h0, 32'hFFFF_FFF0 + 32'd257698040);
    send(CMD_SET, 16'hFFFF, 32'h0, 32'h0);
    send(CMD_SCHED, 16'h0, 32'hFFFF_FFFF, 32'h0);
    send(CMD_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);

    // Random moves with some noise items between them
    clock_us = $urandom();
    while (items_sent < TOTAL_ITEMS) begin
      if (!hold_done && items_sent >= 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // Drop the offer and wait until every owed result is back
      if (!drain_done && items_sent >= 800) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (shadow.results_due.size() != 0) @(posedge clk);
        drain_done = 1'b1;
      end
      idle_on = !(items_sent >= 1000 && items_sent < 1300);
      if ($urandom_range(9) == 0)
        send(cmd_e_t'($urandom_range(3)), 16'($urandom()), $urandom(), $urandom());
      else
        run_move();
    end
    @(negedge clk);
    req_ch.valid = 1'b0;

    // Drain, then let any stray result show up
    while (shadow.results_due.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < TAIL_CYCLES) begin
      @(posedge clk);
      tail++;
    end
    if (shadow.results_due.size() != 0) begin
      shadow.errors++;
      $display("%0t: %0d results never arrived", $time, shadow.results_due.size());
    end

    $display("Sent %0d items, checked %0d results: %0d moves reached target, %0d acks fired",
             items_sent, shadow.results_checked, shadow.arrivals, shadow.acks_fired);
    $display("Included a long output hold-off, a full drain pause and a gap-free stretch");
    if (shadow.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
